// ===== hw/rtl/xles_pkg.sv =====
package xles_pkg;

   localparam int unsigned MAX_ELEMENT_DEPTH_DEF = 255;
   localparam int unsigned MAX_EMBED_DEPTH_DEF   = 15;
   localparam int unsigned MAX_TOKEN_LEN_DEF     = 65535;

   localparam int unsigned CH_W       = 21;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned LEN_W      = 16;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 24;

   typedef enum logic [STATUS_W-1:0] {
      ST_CONTINUE = 3'd0,
      ST_ACCEPT   = 3'd1,
      ST_REJECT   = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_IDLE     = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      M_IDLE      = 5'd0,
      M_START     = 5'd1,
      M_NAME      = 5'd2,
      M_TAG       = 5'd3,
      M_TAG_LT    = 5'd4,
      M_TAG_SLASH = 5'd5,
      M_TEXT      = 5'd6,
      M_TEXT_LT   = 5'd7,
      M_BANG      = 5'd8,
      M_COMMENT   = 5'd9,
      M_CDATA     = 5'd10,
      M_DOCTYPE   = 5'd11,
      M_PI        = 5'd12,
      M_PI_Q      = 5'd13,
      M_EMB       = 5'd14,
      M_EMB_LT    = 5'd15,
      M_EMB_PCT   = 5'd16,
      M_STR       = 5'd17,
      M_STR_Q     = 5'd18
   } scan_mode_type;

   typedef enum logic [1:0] {
      Q_NONE   = 2'd0,
      Q_DOUBLE = 2'd1,
      Q_SINGLE = 2'd2
   } quote_type;

   typedef struct packed {
      scan_mode_type mode;
      logic          inside_tag;
      logic          closing_tag;
      quote_type     quote;
      logic [1:0]    run_count;
      logic          embed_returns_to_tag;
   } ctrl_type;

endpackage

// ===== hw/rtl/xles_step.sv =====
module xles_step #(
   parameter int unsigned MAX_ELEMENT_DEPTH = xles_pkg::MAX_ELEMENT_DEPTH_DEF,
   parameter int unsigned MAX_EMBED_DEPTH   = xles_pkg::MAX_EMBED_DEPTH_DEF,
   parameter int unsigned MAX_TOKEN_LEN     = xles_pkg::MAX_TOKEN_LEN_DEF,
   localparam int unsigned EW = $clog2(MAX_ELEMENT_DEPTH + 1),
   localparam int unsigned MW = $clog2(MAX_EMBED_DEPTH + 1),
   localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1)
) (
   input  logic                          start_req,
   input  logic [xles_pkg::CH_W-1:0]     ch,
   input  xles_pkg::ctrl_type            cur_ctrl,
   input  logic [EW-1:0]                 cur_elem_depth,
   input  logic [MW-1:0]                 cur_embed_depth,
   input  logic [CW-1:0]                 cur_char_count,
   output xles_pkg::ctrl_type            nxt_ctrl,
   output logic [EW-1:0]                 nxt_elem_depth,
   output logic [MW-1:0]                 nxt_embed_depth,
   output logic [CW-1:0]                 nxt_char_count,
   output xles_pkg::status_type          status,
   output logic [xles_pkg::LEN_W-1:0]    token_length
);

   localparam logic [xles_pkg::CH_W-1:0] CH_NUL   = 21'h00;
   localparam logic [xles_pkg::CH_W-1:0] CH_TAB   = 21'h09;
   localparam logic [xles_pkg::CH_W-1:0] CH_SPACE = 21'h20;
   localparam logic [xles_pkg::CH_W-1:0] CH_LT    = 21'h3C;
   localparam logic [xles_pkg::CH_W-1:0] CH_PCT   = 21'h25;
   localparam logic [xles_pkg::CH_W-1:0] CH_GT    = 21'h3E;
   localparam logic [xles_pkg::CH_W-1:0] CH_DQ    = 21'h22;
   localparam logic [xles_pkg::CH_W-1:0] CH_SQ    = 21'h27;
   localparam logic [xles_pkg::CH_W-1:0] CH_SLASH = 21'h2F;
   localparam logic [xles_pkg::CH_W-1:0] CH_BANG  = 21'h21;
   localparam logic [xles_pkg::CH_W-1:0] CH_QUEST = 21'h3F;
   localparam logic [xles_pkg::CH_W-1:0] CH_DASH  = 21'h2D;
   localparam logic [xles_pkg::CH_W-1:0] CH_LBRK  = 21'h5B;
   localparam logic [xles_pkg::CH_W-1:0] CH_RBRK  = 21'h5D;
   localparam logic [xles_pkg::CH_W-1:0] CH_UNDER = 21'h5F;

   function automatic logic name_start(input logic [xles_pkg::CH_W-1:0] c);
      name_start = (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A) ||
                   (c == CH_UNDER);
   endfunction

   xles_pkg::status_type st;
   logic                 done;
   logic [xles_pkg::CH_W-1:0] mark;

   // next state
   always_comb begin
      nxt_ctrl        = cur_ctrl;
      nxt_elem_depth  = cur_elem_depth;
      nxt_embed_depth = cur_embed_depth;
      nxt_char_count  = cur_char_count;
      st              = xles_pkg::ST_CONTINUE;
      done            = 1'b0;
      mark            = CH_DASH;

      if (start_req) begin
         nxt_ctrl.mode                 = xles_pkg::M_START;
         nxt_ctrl.inside_tag           = 1'b1;
         nxt_ctrl.closing_tag          = 1'b0;
         nxt_ctrl.quote                = xles_pkg::Q_NONE;
         nxt_ctrl.run_count            = 2'd0;
         nxt_ctrl.embed_returns_to_tag = 1'b0;
         nxt_elem_depth                = '0;
         nxt_embed_depth               = '0;
         nxt_char_count                = '0;
      end

      if (nxt_ctrl.mode == xles_pkg::M_IDLE) begin
         st = xles_pkg::ST_IDLE;
      end else if (nxt_ctrl.mode == xles_pkg::M_START) begin
         if (ch == CH_SPACE || ch == CH_TAB) begin
            st = xles_pkg::ST_CONTINUE;
         end else if (ch == CH_LT) begin
            nxt_char_count = CW'(1);
            nxt_ctrl.mode  = xles_pkg::M_NAME;
         end else begin
            st = xles_pkg::ST_REJECT;
         end
      end else if (ch == CH_NUL) begin
         st = xles_pkg::ST_REJECT;
      end else if (nxt_char_count >= CW'(MAX_TOKEN_LEN)) begin
         st = xles_pkg::ST_OVERFLOW;
      end else begin
         nxt_char_count = nxt_char_count + CW'(1);

         // lookahead modes: resolve the pending mark, or fall back to the base mode
         case (nxt_ctrl.mode)
            xles_pkg::M_TAG_LT: begin
               if (ch == CH_PCT) begin
                  nxt_embed_depth               = MW'(1);
                  nxt_ctrl.embed_returns_to_tag = 1'b1;
                  nxt_ctrl.mode                 = xles_pkg::M_EMB;
                  done                          = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_TAG;
               end
            end
            xles_pkg::M_TAG_SLASH: begin
               if (ch == CH_GT) begin
                  nxt_ctrl.inside_tag = 1'b0;
                  if (nxt_elem_depth == '0) st = xles_pkg::ST_ACCEPT;
                  else nxt_ctrl.mode = xles_pkg::M_TEXT;
                  done = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_TAG;
               end
            end
            xles_pkg::M_TEXT_LT: begin
               done = 1'b1;
               if (ch == CH_SLASH) begin
                  nxt_ctrl.closing_tag = 1'b1;
                  nxt_ctrl.inside_tag  = 1'b1;
                  nxt_ctrl.mode        = xles_pkg::M_TAG;
               end else if (ch == CH_PCT) begin
                  nxt_embed_depth               = MW'(1);
                  nxt_ctrl.embed_returns_to_tag = 1'b0;
                  nxt_ctrl.mode                 = xles_pkg::M_EMB;
               end else if (ch == CH_BANG) begin
                  nxt_ctrl.mode = xles_pkg::M_BANG;
               end else if (ch == CH_QUEST) begin
                  nxt_ctrl.mode = xles_pkg::M_PI;
               end else begin
                  nxt_ctrl.closing_tag = 1'b0;
                  nxt_ctrl.inside_tag  = 1'b1;
                  nxt_ctrl.mode        = xles_pkg::M_TAG;
                  done                 = 1'b0;
               end
            end
            xles_pkg::M_BANG: begin
               if (ch == CH_DASH) begin
                  nxt_ctrl.mode      = xles_pkg::M_COMMENT;
                  nxt_ctrl.run_count = 2'd1;
                  done               = 1'b1;
               end else if (ch == CH_LBRK) begin
                  nxt_ctrl.mode      = xles_pkg::M_CDATA;
                  nxt_ctrl.run_count = 2'd0;
                  done               = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_DOCTYPE;
               end
            end
            xles_pkg::M_PI_Q: begin
               if (ch == CH_GT) begin
                  nxt_ctrl.mode = xles_pkg::M_TEXT;
                  done          = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_PI;
               end
            end
            xles_pkg::M_EMB_LT: begin
               if (ch == CH_PCT) begin
                  if (nxt_embed_depth >= MW'(MAX_EMBED_DEPTH)) begin
                     st = xles_pkg::ST_OVERFLOW;
                  end else begin
                     nxt_embed_depth = nxt_embed_depth + MW'(1);
                     nxt_ctrl.mode   = xles_pkg::M_EMB;
                  end
                  done = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_EMB;
               end
            end
            xles_pkg::M_EMB_PCT: begin
               if (ch == CH_GT) begin
                  if (nxt_embed_depth != '0) nxt_embed_depth = nxt_embed_depth - MW'(1);
                  if (nxt_embed_depth == '0) begin
                     nxt_ctrl.mode = nxt_ctrl.embed_returns_to_tag ? xles_pkg::M_TAG :
                                                                     xles_pkg::M_TEXT;
                  end else begin
                     nxt_ctrl.mode = xles_pkg::M_EMB;
                  end
                  done = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_EMB;
               end
            end
            xles_pkg::M_STR_Q: begin
               if (ch == CH_DQ) begin
                  nxt_ctrl.mode = xles_pkg::M_STR;
                  done          = 1'b1;
               end else begin
                  nxt_ctrl.mode = xles_pkg::M_EMB;
               end
            end
            default: begin
            end
         endcase

         if (!done) begin
            case (nxt_ctrl.mode)
               xles_pkg::M_NAME: begin
                  if (name_start(ch)) nxt_ctrl.mode = xles_pkg::M_TAG;
                  else st = xles_pkg::ST_REJECT;
               end
               xles_pkg::M_TAG: begin
                  if (nxt_ctrl.quote != xles_pkg::Q_NONE) begin
                     if ((nxt_ctrl.quote == xles_pkg::Q_DOUBLE && ch == CH_DQ) ||
                         (nxt_ctrl.quote == xles_pkg::Q_SINGLE && ch == CH_SQ))
                        nxt_ctrl.quote = xles_pkg::Q_NONE;
                  end else if (ch == CH_DQ) begin
                     nxt_ctrl.quote = xles_pkg::Q_DOUBLE;
                  end else if (ch == CH_SQ) begin
                     nxt_ctrl.quote = xles_pkg::Q_SINGLE;
                  end else if (ch == CH_LT) begin
                     nxt_ctrl.mode = xles_pkg::M_TAG_LT;
                  end else if (ch == CH_SLASH) begin
                     nxt_ctrl.mode = xles_pkg::M_TAG_SLASH;
                  end else if (ch == CH_GT) begin
                     if (nxt_ctrl.closing_tag) begin
                        if (nxt_elem_depth <= EW'(1)) begin
                           nxt_elem_depth = '0;
                           st             = xles_pkg::ST_ACCEPT;
                        end else begin
                           nxt_elem_depth      = nxt_elem_depth - EW'(1);
                           nxt_ctrl.inside_tag = 1'b0;
                           nxt_ctrl.mode       = xles_pkg::M_TEXT;
                        end
                     end else if (nxt_elem_depth >= EW'(MAX_ELEMENT_DEPTH)) begin
                        st = xles_pkg::ST_OVERFLOW;
                     end else begin
                        nxt_elem_depth      = nxt_elem_depth + EW'(1);
                        nxt_ctrl.inside_tag = 1'b0;
                        nxt_ctrl.mode       = xles_pkg::M_TEXT;
                     end
                  end
               end
               xles_pkg::M_TEXT: begin
                  if (ch == CH_LT) nxt_ctrl.mode = xles_pkg::M_TEXT_LT;
               end
               xles_pkg::M_COMMENT, xles_pkg::M_CDATA: begin
                  mark = (nxt_ctrl.mode == xles_pkg::M_COMMENT) ? CH_DASH : CH_RBRK;
                  if (ch == mark) begin
                     if (nxt_ctrl.run_count < 2'd2)
                        nxt_ctrl.run_count = nxt_ctrl.run_count + 2'd1;
                  end else if (ch == CH_GT && nxt_ctrl.run_count >= 2'd2) begin
                     nxt_ctrl.run_count = 2'd0;
                     nxt_ctrl.mode      = xles_pkg::M_TEXT;
                  end else begin
                     nxt_ctrl.run_count = 2'd0;
                  end
               end
               xles_pkg::M_DOCTYPE: begin
                  if (ch == CH_GT) nxt_ctrl.mode = xles_pkg::M_TEXT;
               end
               xles_pkg::M_PI: begin
                  if (ch == CH_QUEST) nxt_ctrl.mode = xles_pkg::M_PI_Q;
               end
               xles_pkg::M_EMB: begin
                  if (ch == CH_DQ) nxt_ctrl.mode = xles_pkg::M_STR;
                  else if (ch == CH_LT) nxt_ctrl.mode = xles_pkg::M_EMB_LT;
                  else if (ch == CH_PCT) nxt_ctrl.mode = xles_pkg::M_EMB_PCT;
               end
               xles_pkg::M_STR: begin
                  if (ch == CH_DQ) nxt_ctrl.mode = xles_pkg::M_STR_Q;
               end
               default: begin
                  st = xles_pkg::ST_REJECT;
               end
            endcase
         end
      end

      if (st != xles_pkg::ST_CONTINUE) nxt_ctrl.mode = xles_pkg::M_IDLE;
   end

   // outputs
   always_comb begin
      status = st;
      if (st == xles_pkg::ST_IDLE) begin
         token_length = '0;
      end else if (32'(nxt_char_count) > 32'd65535) begin
         token_length = '1;
      end else begin
         token_length = xles_pkg::LEN_W'(nxt_char_count);
      end
   end

endmodule

// ===== hw/rtl/xml_literal_extent_scanner_unit.sv =====
// Inline XML literal extent scanner. Feed one code point per word on the req
// stream (tuser high on the first character of a scan attempt, code point 0 for
// end of input); every accepted word yields exactly one rsp word with a status
// (continue, accepted, rejected, capacity overflow, idle) and the literal length
// counted so far, saturated to 16 bits. The block sustains one word per cycle
// while the rsp side is not stalled: the scanner state update is a single pass
// of logic between the input register and the result register, so a word passes
// through the input register and then the result register, and a stalled rsp side
// holds one result while one more word waits in the input register.
module xml_literal_extent_scanner_unit #(
   parameter int unsigned MAX_ELEMENT_DEPTH = xles_pkg::MAX_ELEMENT_DEPTH_DEF,
   parameter int unsigned MAX_EMBED_DEPTH   = xles_pkg::MAX_EMBED_DEPTH_DEF,
   parameter int unsigned MAX_TOKEN_LEN     = xles_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [xles_pkg::REQ_DATA_W-1:0]   req_tdata,   // [20:0] ch, [23:21] zero
   input  logic                              req_tuser,   // [0] start_req
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [xles_pkg::RSP_DATA_W-1:0]   rsp_tdata    // [2:0] status, [18:3] token_length
);

   localparam int unsigned EW = $clog2(MAX_ELEMENT_DEPTH + 1);
   localparam int unsigned MW = $clog2(MAX_EMBED_DEPTH + 1);
   localparam int unsigned CW = $clog2(MAX_TOKEN_LEN + 1);

   logic                          in_valid_ff, in_valid_in;
   logic                          in_start_ff;
   logic [xles_pkg::CH_W-1:0]     in_ch_ff;
   logic                          out_valid_ff, out_valid_in;
   xles_pkg::status_type          out_status_ff;
   logic [xles_pkg::LEN_W-1:0]    out_len_ff;

   xles_pkg::ctrl_type            ctrl_ff, ctrl_in;
   logic [EW-1:0]                 elem_depth_ff, elem_depth_in;
   logic [MW-1:0]                 embed_depth_ff, embed_depth_in;
   logic [CW-1:0]                 char_count_ff, char_count_in;
   xles_pkg::status_type          step_status;
   logic [xles_pkg::LEN_W-1:0]    step_len;

   logic advance;
   logic req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   xles_step #(
      .MAX_ELEMENT_DEPTH (MAX_ELEMENT_DEPTH),
      .MAX_EMBED_DEPTH   (MAX_EMBED_DEPTH),
      .MAX_TOKEN_LEN     (MAX_TOKEN_LEN)
   ) u_step (
      .start_req       (in_start_ff),
      .ch              (in_ch_ff),
      .cur_ctrl        (ctrl_ff),
      .cur_elem_depth  (elem_depth_ff),
      .cur_embed_depth (embed_depth_ff),
      .cur_char_count  (char_count_ff),
      .nxt_ctrl        (ctrl_in),
      .nxt_elem_depth  (elem_depth_in),
      .nxt_embed_depth (embed_depth_in),
      .nxt_char_count  (char_count_in),
      .status          (step_status),
      .token_length    (step_len)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                  <= 1'b0;
         out_valid_ff                 <= 1'b0;
         ctrl_ff.mode                 <= xles_pkg::M_IDLE;
         ctrl_ff.inside_tag           <= 1'b1;
         ctrl_ff.closing_tag          <= 1'b0;
         ctrl_ff.quote                <= xles_pkg::Q_NONE;
         ctrl_ff.run_count            <= 2'd0;
         ctrl_ff.embed_returns_to_tag <= 1'b0;
         elem_depth_ff                <= '0;
         embed_depth_ff               <= '0;
         char_count_ff                <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            ctrl_ff        <= ctrl_in;
            elem_depth_ff  <= elem_depth_in;
            embed_depth_ff <= embed_depth_in;
            char_count_ff  <= char_count_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_start_ff <= req_tuser;
         in_ch_ff    <= req_tdata[xles_pkg::CH_W-1:0];
      end
      if (advance) begin
         out_status_ff <= step_status;
         out_len_ff    <= step_len;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(xles_pkg::RSP_DATA_W - xles_pkg::LEN_W - xles_pkg::STATUS_W){1'b0}},
                        out_len_ff, out_status_ff};

endmodule

// ===== hw/rtl/xles_checker.sv =====
module xles_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [xles_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [xles_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   logic [xles_pkg::STATUS_W-1:0] rsp_status;
   logic [xles_pkg::LEN_W-1:0]    rsp_len;
   logic                          req_word;

   assign rsp_status = rsp_tdata[2:0];
   assign rsp_len    = rsp_tdata[18:3];
   assign req_word   = req_tvalid && req_tready && (req_tdata[23:21] == 3'd0 || req_tuser);

   // no result can come out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an idle report carries no length
   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == xles_pkg::ST_IDLE |-> rsp_len == '0)
      else $error("idle result with nonzero length");

   // the shortest literal that can be accepted is a self-closed one-letter root
   a_accept_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == xles_pkg::ST_ACCEPT |-> rsp_len >= 16'd4)
      else $error("accepted literal too short");

   // a word taken while no result is valid goes through the input register and then shows up as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_word && !rsp_tvalid |=> ##1 rsp_tvalid)
      else $error("result missing after accepted word");

endmodule

bind xml_literal_extent_scanner_unit xles_checker u_xles_checker (.*);
